@@ sv/dchl_pkg.sv @@
package dchl_pkg;

    // default table shape
    localparam int MODULES_DEF = 4;
    localparam int LAYERS_DEF  = 6;

    // angles in 1/64 degree
    localparam int FULL_TURN    = 23040;
    localparam int HALF_TURN    = 11520;
    localparam int QUARTER_TURN = 5760;

    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_START = 39797;
    localparam int ROOT_STEPS   = 17;
    localparam int DIV_STEPS    = 8;

    // cordic datapath widths
    localparam int XW = 19;
    localparam int ZW = 24;

    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_HIT  = 1'b1
    } func_t;

    typedef struct packed {
        logic [15:0]        pitch;
        logic signed [13:0] wangle;
        logic [7:0]         central;
        logic [7:0]         count;
    } geom_t;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } rot_t;

    typedef struct packed {
        logic signed [ZW-1:0] z;
        logic                 neg;
    } red_t;

    typedef struct packed {
        logic [33:0] rem;
        logic [33:0] root;
    } root_t;

    typedef struct packed {
        logic [7:0]  quot;
        logic [40:0] rem;
    } div_t;

    // arctangent of 2^-i in 1/16384 degree
    function automatic logic signed [ZW-1:0] atan_step(input int step);
        case (step)
            0:       return 24'sd737280;
            1:       return 24'sd435242;
            2:       return 24'sd229970;
            3:       return 24'sd116736;
            4:       return 24'sd58595;
            5:       return 24'sd29326;
            6:       return 24'sd14667;
            7:       return 24'sd7334;
            8:       return 24'sd3667;
            9:       return 24'sd1833;
            10:      return 24'sd917;
            11:      return 24'sd458;
            12:      return 24'sd229;
            13:      return 24'sd115;
            14:      return 24'sd57;
            default: return 24'sd29;
        endcase
    endfunction

    // fold an angle into [-90,90] degrees, scaled for the cordic accumulator
    function automatic red_t angle_reduce(input logic signed [16:0] ang);
        logic signed [17:0] a;
        red_t               res;
        a = 18'(ang);
        res.neg = 1'b0;
        if (a < 0) begin
            a = a + 18'(FULL_TURN);
        end else if (a >= 18'(FULL_TURN)) begin
            a = a - 18'(FULL_TURN);
        end
        if (a > 18'(HALF_TURN)) begin
            a = a - 18'(FULL_TURN);
        end
        if (a > 18'(QUARTER_TURN)) begin
            a = a - 18'(HALF_TURN);
            res.neg = 1'b1;
        end else if (a < -18'(QUARTER_TURN)) begin
            a = a + 18'(HALF_TURN);
            res.neg = 1'b1;
        end
        res.z = ZW'(a) <<< 8;
        return res;
    endfunction

    // clamp to +-1.0 in q16 and apply the half-turn sign
    function automatic logic signed [17:0] clamp_q16(input logic signed [XW-1:0] v,
                                                     input logic neg);
        logic signed [17:0] c;
        if (v > XW'(65536)) begin
            c = 18'sd65536;
        end else if (v < -XW'(65536)) begin
            c = -18'sd65536;
        end else begin
            c = 18'(v);
        end
        return neg ? -c : c;
    endfunction

endpackage

@@ sv/drift_cell_hit_locator.sv @@
// drift cell hit locator: a load transaction (func 0) writes one geometry entry
// (pitch, wire angle, central wire, wire count) of the module x layer table; a hit
// transaction (func 1) gives one result with the fired cell, the rounded offset to
// its wire and the shortest track-to-wire distance, all in 1/256 mm. the block
// takes one transaction per clock while no blocked result stalls it; most of
// its pipeline is the 16-step cordic chains (wire angle, incidence, azimuth minus
// wire angle) and the 17-step square root chain. a finished result waiting at
// the output does not stop new transactions until the next result reaches the
// last stage before the output register. a load is visible to a hit taken in
// the next cycle. reading a table entry never loaded gives garbage.
module drift_cell_hit_locator #(
    parameter int MODULES = dchl_pkg::MODULES_DEF,
    parameter int LAYERS  = dchl_pkg::LAYERS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // item channel
    input  logic        item_valid,
    output logic        item_ready,
    input  logic        func,
    input  logic [1:0]  module_index,
    input  logic [2:0]  layer_index,
    input  logic signed [23:0] x_pos,
    input  logic signed [23:0] y_pos,
    input  logic [12:0] incidence_angle,
    input  logic [14:0] azimuth_angle,
    input  logic [15:0] wire_pitch,
    input  logic signed [13:0] wire_angle,
    input  logic [7:0]  central_wire,
    input  logic [7:0]  wire_count,
    // result channel
    output logic        result_valid,
    input  logic        result_ready,
    output logic        in_range,
    output logic [7:0]  cell_index,
    output logic [23:0] wire_offset,
    output logic [23:0] track_distance
);
    import dchl_pkg::*;

    localparam int DEPTH = MODULES * LAYERS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef struct packed {
        logic               ok;
        logic signed [23:0] x;
        logic signed [23:0] y;
        geom_t              g;
        logic [2:0]         neg;
    } side1_t;

    typedef struct packed {
        logic        inr;
        logic [15:0] p;
    } side2_t;

    // ------------------------------------------------------------------
    // flow control: everything moves unless a result waits behind one that is blocked
    // ------------------------------------------------------------------
    logic adv;
    logic accept;
    logic d_valid_reg;
    logic result_valid_reg;
    logic result_valid_next;

    assign adv        = !result_valid_reg || result_ready || !d_valid_reg;
    assign item_ready = adv;
    assign accept     = item_valid && adv;

    // ------------------------------------------------------------------
    // geometry table
    // ------------------------------------------------------------------
    logic          idx_ok;
    logic [AW-1:0] addr;
    geom_t         wr_geom;
    logic [45:0]   rd_word;

    assign idx_ok = (int'(module_index) < MODULES) && (int'(layer_index) < LAYERS);
    assign addr   = idx_ok ? AW'(int'(module_index) * LAYERS + int'(layer_index)) : '0;

    always_comb
    begin
        wr_geom.pitch   = wire_pitch;
        wr_geom.wangle  = wire_angle;
        wr_geom.central = central_wire;
        wr_geom.count   = wire_count;
    end

    dchl_ram #(
        .WIDTH  (46),
        .DEPTH  (DEPTH),
        .ADDR_W (AW)
    ) u_geom_ram (
        .clk     (clk),
        .wr_en   (accept && (func == FUNC_LOAD) && idx_ok),
        .wr_addr (addr),
        .wr_data (wr_geom),
        .rd_en   (adv),
        .rd_addr (addr),
        .rd_data (rd_word)
    );

    // ------------------------------------------------------------------
    // stage 1: hit fields beside the table read
    // ------------------------------------------------------------------
    logic               s1_valid_reg;
    logic               s1_ok_reg;
    logic signed [23:0] s1_x_reg;
    logic signed [23:0] s1_y_reg;
    logic [12:0]        s1_inc_reg;
    logic [14:0]        s1_az_reg;
    geom_t              g1;

    assign g1 = geom_t'(rd_word);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= accept && (func == FUNC_HIT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ok_reg  <= idx_ok;
            s1_x_reg   <= x_pos;
            s1_y_reg   <= y_pos;
            s1_inc_reg <= incidence_angle;
            s1_az_reg  <= azimuth_angle;
        end
    end

    // ------------------------------------------------------------------
    // angle folding and cordic seeds
    // lane 0: wire angle, lane 1: incidence, lane 2: azimuth minus wire angle
    // ------------------------------------------------------------------
    red_t   red [3];
    rot_t   prep_rot_reg [3];
    rot_t   rot_w [3][CORDIC_STEPS+1];
    side1_t side1_reg [CORDIC_STEPS+1];
    logic   valid1_reg [CORDIC_STEPS+1];

    always_comb
    begin
        red[0] = angle_reduce(17'(g1.wangle));
        red[1] = angle_reduce(signed'({4'b0, s1_inc_reg}));
        red[2] = angle_reduce(signed'({2'b0, s1_az_reg}) - 17'(g1.wangle));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < 3; l++)
            begin
                prep_rot_reg[l].x <= XW'(CORDIC_START);
                prep_rot_reg[l].y <= '0;
                prep_rot_reg[l].z <= red[l].z;
            end
            side1_reg[0].ok  <= s1_ok_reg;
            side1_reg[0].x   <= s1_x_reg;
            side1_reg[0].y   <= s1_y_reg;
            side1_reg[0].g   <= g1;
            side1_reg[0].neg <= {red[2].neg, red[1].neg, red[0].neg};
            for (int k = 0; k < CORDIC_STEPS; k++)
            begin
                side1_reg[k+1] <= side1_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= CORDIC_STEPS; k++)
            begin
                valid1_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            valid1_reg[0] <= s1_valid_reg;
            for (int k = 0; k < CORDIC_STEPS; k++)
            begin
                valid1_reg[k+1] <= valid1_reg[k];
            end
        end
    end

    // three cordic chains side by side
    for (genvar l = 0; l < 3; l++)
    begin : g_lane
        assign rot_w[l][0] = prep_rot_reg[l];
        for (genvar k = 0; k < CORDIC_STEPS; k++)
        begin : g_step
            dchl_cordic_cell #(
                .STEP (k)
            ) u_cell (
                .clk     (clk),
                .en      (adv),
                .rot_in  (rot_w[l][k]),
                .rot_out (rot_w[l][k+1])
            );
        end
    end

    // ------------------------------------------------------------------
    // stage a: clamp, then the rotation and projection products
    // ------------------------------------------------------------------
    side1_t             e1;
    logic signed [17:0] sw;
    logic signed [17:0] cw;
    logic signed [17:0] st;
    logic signed [17:0] cp;
    logic signed [17:0] st_neg;
    logic signed [17:0] cp_neg;
    logic [16:0]        st_abs;
    logic [16:0]        cp_abs;
    logic signed [9:0]  c2;
    logic signed [9:0]  n2;

    logic               a_valid_reg;
    logic               a_ok_reg;
    logic [15:0]        a_p_reg;
    logic signed [41:0] a_ycw_reg;
    logic signed [41:0] a_xsw_reg;
    logic [33:0]        a_mp_reg;
    logic signed [26:0] a_base_reg;
    logic signed [26:0] a_hib_reg;

    assign e1 = side1_reg[CORDIC_STEPS];

    always_comb
    begin
        sw     = clamp_q16(rot_w[0][CORDIC_STEPS].y, e1.neg[0]);
        cw     = clamp_q16(rot_w[0][CORDIC_STEPS].x, e1.neg[0]);
        st     = clamp_q16(rot_w[1][CORDIC_STEPS].y, e1.neg[1]);
        cp     = clamp_q16(rot_w[2][CORDIC_STEPS].x, e1.neg[2]);
        st_neg = -st;
        cp_neg = -cp;
        st_abs = st[17] ? st_neg[16:0] : st[16:0];
        cp_abs = cp[17] ? cp_neg[16:0] : cp[16:0];
        // 2*central-1 and 2*count-1, in half pitches
        c2     = signed'({1'b0, e1.g.central, 1'b0}) - 10'sd1;
        n2     = signed'({1'b0, e1.g.count, 1'b0}) - 10'sd1;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_ok_reg   <= e1.ok;
            a_p_reg    <= e1.g.pitch;
            a_ycw_reg  <= e1.y * cw;
            a_xsw_reg  <= e1.x * sw;
            a_mp_reg   <= st_abs * cp_abs;
            a_base_reg <= c2 * signed'({1'b0, e1.g.pitch});
            a_hib_reg  <= n2 * signed'({1'b0, e1.g.pitch});
        end
    end

    // ------------------------------------------------------------------
    // stage b: distance along the grid, range check, rounded projection
    // ------------------------------------------------------------------
    logic signed [43:0] grid_dist;
    logic signed [43:0] hi;
    logic [34:0]        mp_round;
    logic               b_valid_reg;
    logic               b_inr_reg;
    logic [15:0]        b_p_reg;
    logic [40:0]        b_rem_reg;
    logic [16:0]        b_m_reg;

    always_comb
    begin
        grid_dist = (44'(a_base_reg) <<< 15) + 44'(a_ycw_reg) - 44'(a_xsw_reg);
        hi        = 44'(a_hib_reg) <<< 15;
        mp_round  = 35'(a_mp_reg) + 35'd32768;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_inr_reg <= a_ok_reg && (a_p_reg != 16'd0) && !grid_dist[43]
                         && (grid_dist <= hi);
            b_p_reg   <= a_p_reg;
            b_rem_reg <= grid_dist[40:0];
            b_m_reg   <= mp_round[32:16];
        end
    end

    // ------------------------------------------------------------------
    // stage c: square of the projection
    // ------------------------------------------------------------------
    logic [33:0] c_mm_reg;
    side2_t      side2_reg [ROOT_STEPS+1];
    logic        valid2_reg [ROOT_STEPS+1];
    logic [40:0] c_rem_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_mm_reg         <= b_m_reg * b_m_reg;
            c_rem_reg        <= b_rem_reg;
            side2_reg[0].inr <= b_inr_reg;
            side2_reg[0].p   <= b_p_reg;
            for (int k = 0; k < ROOT_STEPS; k++)
            begin
                side2_reg[k+1] <= side2_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            for (int k = 0; k <= ROOT_STEPS; k++)
            begin
                valid2_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            a_valid_reg   <= valid1_reg[CORDIC_STEPS];
            b_valid_reg   <= a_valid_reg;
            valid2_reg[0] <= b_valid_reg;
            for (int k = 0; k < ROOT_STEPS; k++)
            begin
                valid2_reg[k+1] <= valid2_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // root chain for sqrt(1 - m^2), cell divider in its first stages
    // ------------------------------------------------------------------
    root_t root_w [ROOT_STEPS+1];
    div_t  div_w [ROOT_STEPS+1];

    assign root_w[0].rem  = 34'h1_0000_0000 - c_mm_reg;
    assign root_w[0].root = '0;
    assign div_w[0].quot  = '0;
    assign div_w[0].rem   = c_rem_reg;

    for (genvar k = 0; k < ROOT_STEPS; k++)
    begin : g_root
        dchl_root_cell #(
            .STEP (k)
        ) u_root (
            .clk      (clk),
            .en       (adv),
            .root_in  (root_w[k]),
            .root_out (root_w[k+1])
        );
        if (k < DIV_STEPS)
        begin : g_div
            dchl_div_cell #(
                .STEP (k)
            ) u_div (
                .clk     (clk),
                .en      (adv),
                .pitch   (side2_reg[k].p),
                .div_in  (div_w[k]),
                .div_out (div_w[k+1])
            );
        end
        else
        begin : g_hold
            div_t hold_reg;
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    hold_reg <= div_w[k];
                end
            end
            assign div_w[k+1] = hold_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage d: offset from the cell wire
    // ------------------------------------------------------------------
    side2_t      e2;
    logic [40:0] half;
    logic [40:0] off;
    logic        d_inr_reg;
    logic [7:0]  d_cell_reg;
    logic [31:0] d_off_reg;
    logic [16:0] d_root_reg;

    assign e2 = side2_reg[ROOT_STEPS];

    always_comb
    begin
        half = 41'(e2.p) << 15;
        if (div_w[ROOT_STEPS].rem >= half)
        begin
            off = div_w[ROOT_STEPS].rem - half;
        end
        else
        begin
            off = half - div_w[ROOT_STEPS].rem;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_inr_reg  <= e2.inr;
            d_cell_reg <= div_w[ROOT_STEPS].quot;
            d_off_reg  <= off[31:0];
            d_root_reg <= root_w[ROOT_STEPS].root[16:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            d_valid_reg <= valid2_reg[ROOT_STEPS];
        end
    end

    // ------------------------------------------------------------------
    // output register: rounding and track distance
    // ------------------------------------------------------------------
    logic [48:0] td_prod;
    logic [49:0] td_sum;
    logic [32:0] wo_sum;
    logic        in_range_reg;
    logic [7:0]  cell_index_reg;
    logic [23:0] wire_offset_reg;
    logic [23:0] track_distance_reg;

    always_comb
    begin
        td_prod = d_off_reg * d_root_reg;
        td_sum  = 50'(td_prod) + 50'h0_0000_8000_0000;
        wo_sum  = 33'(d_off_reg) + 33'd32768;
        if (!adv)
        begin
            result_valid_next = result_valid_reg;
        end
        else if (d_valid_reg)
        begin
            result_valid_next = 1'b1;
        end
        else
        begin
            result_valid_next = result_valid_reg && !result_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && d_valid_reg)
        begin
            in_range_reg       <= d_inr_reg;
            cell_index_reg     <= d_inr_reg ? d_cell_reg : 8'd0;
            wire_offset_reg    <= d_inr_reg ? 24'(wo_sum[32:16]) : 24'd0;
            track_distance_reg <= d_inr_reg ? 24'(td_sum[49:32]) : 24'd0;
        end
    end

    assign result_valid   = result_valid_reg;
    assign in_range       = in_range_reg;
    assign cell_index     = cell_index_reg;
    assign wire_offset    = wire_offset_reg;
    assign track_distance = track_distance_reg;

`ifndef ASSERT_OFF
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !in_range |->
            cell_index == 8'd0 && wire_offset == 24'd0 && track_distance == 24'd0)
        else $error("out-of-range result carries nonzero fields");

    a_half_pitch: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && in_range |-> wire_offset <= 24'd32768)
        else $error("wire offset beyond half a pitch");

    a_track_le_off: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> track_distance <= wire_offset)
        else $error("track distance exceeds wire offset");

    a_hit_enters: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && func == FUNC_HIT |=> s1_valid_reg)
        else $error("accepted hit lost at pipeline entry");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && func == FUNC_LOAD |=> !s1_valid_reg)
        else $error("load transaction entered the hit pipeline");
`endif

endmodule

@@ sv/dchl_ram.sv @@
module dchl_ram #(
    parameter int WIDTH  = 46,
    parameter int DEPTH  = 24,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/dchl_cordic_cell.sv @@
module dchl_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic           clk,
    input  logic           en,
    input  dchl_pkg::rot_t rot_in,
    output dchl_pkg::rot_t rot_out
);
    import dchl_pkg::*;

    rot_t                 rot_next;
    rot_t                 rot_reg;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;

    // one micro-rotation, direction from the residual angle sign
    always_comb
    begin
        dx = rot_in.y >>> STEP;
        dy = rot_in.x >>> STEP;
        if (!rot_in.z[ZW-1])
        begin
            rot_next.x = rot_in.x - dx;
            rot_next.y = rot_in.y + dy;
            rot_next.z = rot_in.z - atan_step(STEP);
        end
        else
        begin
            rot_next.x = rot_in.x + dx;
            rot_next.y = rot_in.y - dy;
            rot_next.z = rot_in.z + atan_step(STEP);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rot_reg <= rot_next;
        end
    end

    assign rot_out = rot_reg;

endmodule

@@ sv/dchl_root_cell.sv @@
module dchl_root_cell #(
    parameter int STEP = 0
) (
    input  logic            clk,
    input  logic            en,
    input  dchl_pkg::root_t root_in,
    output dchl_pkg::root_t root_out
);
    import dchl_pkg::*;

    localparam logic [33:0] BIT = 34'(1) << (32 - 2 * STEP);

    root_t       root_next;
    root_t       root_reg;
    logic [33:0] trial;

    // one bit of the digit-by-digit square root
    always_comb
    begin
        trial = root_in.root + BIT;
        if (root_in.rem >= trial)
        begin
            root_next.rem  = root_in.rem - trial;
            root_next.root = (root_in.root >> 1) + BIT;
        end
        else
        begin
            root_next.rem  = root_in.rem;
            root_next.root = root_in.root >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            root_reg <= root_next;
        end
    end

    assign root_out = root_reg;

endmodule

@@ sv/dchl_div_cell.sv @@
module dchl_div_cell #(
    parameter int STEP = 0
) (
    input  logic           clk,
    input  logic           en,
    input  logic [15:0]    pitch,
    input  dchl_pkg::div_t div_in,
    output dchl_pkg::div_t div_out
);
    import dchl_pkg::*;

    localparam int SHIFT = 16 + DIV_STEPS - 1 - STEP;

    div_t        div_next;
    div_t        div_reg;
    logic [40:0] dvs;

    // one restoring quotient bit, msb first
    always_comb
    begin
        dvs = 41'(pitch) << SHIFT;
        if (div_in.rem >= dvs)
        begin
            div_next.rem  = div_in.rem - dvs;
            div_next.quot = {div_in.quot[6:0], 1'b1};
        end
        else
        begin
            div_next.rem  = div_in.rem;
            div_next.quot = {div_in.quot[6:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg <= div_next;
        end
    end

    assign div_out = div_reg;

endmodule
